>>> rtl/ipr_pkg.sv
// Package for the ICMP probe reply matcher: shared constants, queue sizing
// and the item type passed from the front end to the back end.
// No dependencies.
package ipr_pkg;

    // Bytes at or beyond this offset are ignored and the position saturates.
    localparam logic [15:0] MAX_PACKET_BYTES   = 16'hFFFF;

    // ICMP type for a time exceeded message.
    localparam logic [7:0]  TIME_EXCEEDED_TYPE = 8'd11;

    // Bytes from the ICMP header to the embedded IP header.
    localparam logic [7:0]  EMBED_SKIP         = 8'd8;

    // Offsets of the identifier and sequence bytes within the ICMP header.
    localparam logic [15:0] ICMP_ID_LO  = 16'd4;
    localparam logic [15:0] ICMP_ID_HI  = 16'd5;
    localparam logic [15:0] ICMP_SEQ_LO = 16'd6;
    localparam logic [15:0] ICMP_SEQ_HI = 16'd7;

    // Source address bytes sit at offsets 12 to 15 of the outer header.
    localparam logic [13:0] SRC_ADDR_WORD = 14'd3;

    // Decoupling queue between front and back end.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // One classified byte, as queued for the back end.
    typedef struct packed {
        logic [7:0]  packet_byte;
        logic [15:0] position;
        logic        start;
        logic        last_byte;
        logic        parse_en;
        logic [15:0] expected_sequence;
    } t_ipr_item;

    // A queue port: an item and its valid flag.
    typedef struct packed {
        logic      valid;
        t_ipr_item item;
    } t_ipr_xfer;

endpackage

>>> rtl/ipr_ifs.sv
// Channel interfaces of the ICMP probe reply matcher: the input byte stream
// and the result stream, each with valid and ready.
// No dependencies.
interface ipr_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  packet_byte;
    logic        first_byte;
    logic        last_byte;
    logic [15:0] expected_sequence;

    modport source (output valid, packet_byte, first_byte, last_byte, expected_sequence,
                    input ready);
    modport sink   (input valid, packet_byte, first_byte, last_byte, expected_sequence,
                    output ready);
endinterface

interface ipr_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  reply_type;
    logic        probe_matched;
    logic [31:0] source_address;
    logic        too_short;

    modport source (output valid, reply_type, probe_matched, source_address, too_short,
                    input ready);
    modport sink   (input valid, reply_type, probe_matched, source_address, too_short,
                    output ready);
endinterface

>>> rtl/ipr_front.sv
// Front end of the ICMP probe reply matcher: accepts bytes, tracks packet
// boundaries and the byte position, and pushes classified items to the queue.
// Depends on ipr_pkg and ipr_in_if.
module ipr_front
    import ipr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    ipr_in_if.sink    i_in,
    input  logic      i_q_full,
    output t_ipr_xfer o_push
);

    logic [15:0] r_pos;
    logic [15:0] n_pos;
    logic        r_in_packet;
    logic        start;
    logic [15:0] position;
    logic        parse_en;
    logic        accept;

    // A transaction is taken whenever the queue has room.
    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && i_in.ready;

    // Work out the position of this byte and whether it starts a packet.
    always_comb begin
        start    = i_in.first_byte || !r_in_packet;
        position = start ? 16'd0 : r_pos;
        parse_en = position < MAX_PACKET_BYTES;
        n_pos    = parse_en ? position + 16'd1 : position;
    end

    // Classified item for the back end.
    always_comb begin
        o_push.valid                  = accept;
        o_push.item.packet_byte       = i_in.packet_byte;
        o_push.item.position          = position;
        o_push.item.start             = start;
        o_push.item.last_byte         = i_in.last_byte;
        o_push.item.parse_en          = parse_en;
        o_push.item.expected_sequence = i_in.expected_sequence;
    end

    // Position counter and packet framing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_in_packet <= 1'b0;
        end else if (accept) begin
            r_pos       <= n_pos;
            r_in_packet <= !i_in.last_byte;
        end
    end

endmodule

>>> rtl/ipr_queue.sv
// Short first-in first-out queue that decouples the front end from the
// back end of the ICMP probe reply matcher.
// Depends on ipr_pkg.
module ipr_queue
    import ipr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_ipr_xfer i_push,
    output logic      o_full,
    output t_ipr_xfer o_head,
    input  logic      i_pop
);

    t_ipr_item             r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]    r_wr_ptr;
    logic [Q_PTR_W-1:0]    r_rd_ptr;
    logic [Q_CNT_W-1:0]    r_count;
    logic [Q_CNT_W-1:0]    n_count;

    function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] ptr);
        ptr_inc = (ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : ptr + 1'b1;
    endfunction

    assign o_full      = r_count == Q_CNT_W'(Q_DEPTH);
    assign o_head.valid = r_count != '0;
    assign o_head.item  = r_mem[r_rd_ptr];

    // Occupancy after this cycle's push and pop.
    always_comb begin
        n_count = r_count;
        if (i_push.valid && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push.valid && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.item;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            r_count <= n_count;
        end
    end

    // The occupancy never passes the depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_CNT_W'(Q_DEPTH))
        else $error("queue occupancy above depth");

    // The back end only pops an item that is present.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_head.valid)
        else $error("pop from empty queue");

    // The front end never pushes into a full queue.
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.valid |-> !o_full)
        else $error("push into full queue");

    // A lone push raises the occupancy by one.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.valid && !i_pop) |=> r_count == $past(r_count) + 1'b1)
        else $error("occupancy did not follow a push");

endmodule

>>> rtl/ipr_back.sv
// Back end of the ICMP probe reply matcher: parses queued bytes, gathers
// type, address, identifier and sequence, and registers one result per packet.
// Depends on ipr_pkg and ipr_out_if.
module ipr_back
    import ipr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  t_ipr_xfer   i_head,
    output logic        o_pop,
    ipr_out_if.source   o_out
);

    logic [15:0] r_own_id;
    logic [7:0]  r_icmp_off,   n_icmp_off;
    logic [7:0]  r_inner_off,  n_inner_off;
    logic [7:0]  r_type,       n_type;
    logic [15:0] r_cap_id,     n_cap_id;
    logic [15:0] r_cap_seq,    n_cap_seq;
    logic [31:0] r_cap_src,    n_cap_src;
    logic [15:0] r_lat_seq,    n_lat_seq;
    logic        r_type_seen,  n_type_seen;
    logic        r_await,      n_await;
    logic        r_seq_done,   n_seq_done;

    logic        r_out_valid;
    logic [7:0]  r_out_type;
    logic        r_out_match;
    logic [31:0] r_out_src;
    logic        r_out_short;

    logic        out_free;
    logic [7:0]  b;
    logic [15:0] p;
    logic [15:0] d;
    logic [7:0]  nib4;

    // An item that ends a packet waits until the result register is free.
    assign out_free = !r_out_valid || o_out.ready;
    assign o_pop    = i_head.valid && (!i_head.item.last_byte || out_free);
    assign b        = i_head.item.packet_byte;
    assign p        = i_head.item.position;
    assign nib4     = {2'b00, b[3:0], 2'b00};

    // Parse one byte against the current packet state.
    always_comb begin
        if (i_head.item.start) begin
            n_icmp_off  = '0;
            n_inner_off = '0;
            n_type      = '0;
            n_cap_id    = '0;
            n_cap_seq   = '0;
            n_cap_src   = '0;
            n_lat_seq   = i_head.item.expected_sequence;
            n_type_seen = 1'b0;
            n_await     = 1'b0;
            n_seq_done  = 1'b0;
        end else begin
            n_icmp_off  = r_icmp_off;
            n_inner_off = r_inner_off;
            n_type      = r_type;
            n_cap_id    = r_cap_id;
            n_cap_seq   = r_cap_seq;
            n_cap_src   = r_cap_src;
            n_lat_seq   = r_lat_seq;
            n_type_seen = r_type_seen;
            n_await     = r_await;
            n_seq_done  = r_seq_done;
        end
        d = p - {8'd0, n_icmp_off};

        if (i_head.item.parse_en) begin
            // The length nibble of byte 0 places the outer ICMP header.
            if (p == 16'd0) begin
                n_icmp_off  = nib4;
                n_inner_off = nib4 + EMBED_SKIP;
                d           = p - {8'd0, nib4};
            end

            // Source address, byte 12 in the top eight bits.
            if (p[15:2] == SRC_ADDR_WORD) begin
                case (p[1:0])
                    2'd0:    n_cap_src[31:24] = n_cap_src[31:24] | b;
                    2'd1:    n_cap_src[23:16] = n_cap_src[23:16] | b;
                    2'd2:    n_cap_src[15:8]  = n_cap_src[15:8]  | b;
                    default: n_cap_src[7:0]   = n_cap_src[7:0]   | b;
                endcase
            end

            if (!n_type_seen) begin
                // Outer ICMP type.
                if (p == {8'd0, n_icmp_off}) begin
                    n_type      = b;
                    n_type_seen = 1'b1;
                    n_await     = b == TIME_EXCEEDED_TYPE;
                end
            end else if (n_await) begin
                // Embedded IP header length places the embedded ICMP header.
                if (p == {8'd0, n_inner_off}) begin
                    n_icmp_off = n_inner_off + nib4;
                    n_await    = 1'b0;
                end
            end else if (p >= {8'd0, n_icmp_off}) begin
                // Identifier and sequence, low byte first.
                case (d)
                    ICMP_ID_LO:  n_cap_id[7:0]   = b;
                    ICMP_ID_HI:  n_cap_id[15:8]  = b;
                    ICMP_SEQ_LO: n_cap_seq[7:0]  = b;
                    ICMP_SEQ_HI: begin
                        n_cap_seq[15:8] = b;
                        n_seq_done      = 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_id <= '0;
        end else if (i_cfg_we) begin
            r_own_id <= i_cfg_wdata;
        end
    end

    // Packet state, updated once per popped item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_icmp_off  <= '0;
            r_inner_off <= '0;
            r_type      <= '0;
            r_cap_id    <= '0;
            r_cap_seq   <= '0;
            r_cap_src   <= '0;
            r_lat_seq   <= '0;
            r_type_seen <= 1'b0;
            r_await     <= 1'b0;
            r_seq_done  <= 1'b0;
        end else if (o_pop) begin
            r_icmp_off  <= n_icmp_off;
            r_inner_off <= n_inner_off;
            r_type      <= n_type;
            r_cap_id    <= n_cap_id;
            r_cap_seq   <= n_cap_seq;
            r_cap_src   <= n_cap_src;
            r_lat_seq   <= n_lat_seq;
            r_type_seen <= n_type_seen;
            r_await     <= n_await;
            r_seq_done  <= n_seq_done;
        end
    end

    // Result register, loaded on the last byte of a packet.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && i_head.item.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.item.last_byte) begin
            r_out_type  <= n_type_seen ? n_type : 8'd0;
            r_out_match <= n_seq_done && (n_cap_id == r_own_id) && (n_cap_seq == n_lat_seq);
            r_out_src   <= n_cap_src;
            r_out_short <= !n_seq_done;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.reply_type     = r_out_type;
    assign o_out.probe_matched  = r_out_match;
    assign o_out.source_address = r_out_src;
    assign o_out.too_short      = r_out_short;

    // A match is never reported for a packet flagged as too short.
    a_match_not_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_match && r_out_short))
        else $error("match reported on truncated packet");

    // A waiting result is never overwritten by a new packet end.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |-> !(o_pop && i_head.item.last_byte))
        else $error("result overwritten while stalled");

    // The embedded header is only awaited after a time exceeded type.
    a_await_type: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_await |-> (r_type_seen && r_type == TIME_EXCEEDED_TYPE))
        else $error("awaiting embedded header without time exceeded type");

endmodule

>>> rtl/icmp_probe_reply_matcher.sv
// Top level of the ICMP probe reply matcher: front end, decoupling queue and
// back end. Depends on ipr_pkg, ipr_ifs, ipr_front, ipr_queue and ipr_back.
//
// Usage:
//   i_in carries a received IPv4 packet one byte per transaction, with first
//   and last marks and the expected sequence of the outstanding probe. A byte
//   after reset or after a last byte starts a new packet on its own.
//   o_out carries one result transaction per packet, issued for its last
//   byte: outer ICMP type, match flag, outer source address, too-short flag.
//   i_cfg_we with i_cfg_wdata writes the prober's own identifier; write it
//   only while no packet is in flight.
// Throughput: one byte per cycle unless a last byte waits on a held result,
//   set by the combinational parse step in the back end; the front end takes
//   a byte each cycle the four-entry queue has room.
// Path: a last byte accepted on i_in is written into the queue, then popped
//   into the result register, which drives o_out.
// Reset (synchronous, active low) empties the queue, drops any result and
//   clears the identifier to zero; no clearing pass is needed.
// Stall: while a result waits on o_out, bytes keep flowing until the next
//   last byte reaches the back end; the queue then fills and i_in.ready falls.
module icmp_probe_reply_matcher
    import ipr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    ipr_in_if.sink      i_in,
    ipr_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);

    t_ipr_xfer push;
    t_ipr_xfer head;
    logic      q_full;
    logic      pop;

    ipr_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (push)
    );

    ipr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (q_full),
        .o_head  (head),
        .i_pop   (pop)
    );

    ipr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_head      (head),
        .o_pop       (pop),
        .o_out       (o_out)
    );

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the ICMP probe reply matcher: streams IPv4 packets
// byte by byte and checks every reply verdict against a local prediction.
// Depends on ipr_pkg, ipr_ifs and the icmp_probe_reply_matcher RTL.
module testbench;
    import ipr_pkg::*;

    // ICMP types used when building replies, besides time exceeded.
    localparam logic [7:0] ICMP_ECHO_REPLY       = 8'd0;
    localparam logic [7:0] ICMP_DEST_UNREACHABLE = 8'd3;
    localparam logic [7:0] ICMP_ECHO_REQUEST     = 8'd8;

    localparam int STALL_LIMIT       = 400;
    localparam int PHASE_BYTES       = 250;
    localparam int SETTLE_CYCLES     = 6;

    // One byte of the input stream with its marks and pacing hints.
    typedef struct packed {
        logic [7:0]  data;
        logic        first;
        logic        last;
        logic [15:0] seq;
        logic        calm;
        logic        hold;
    } t_rx_byte;

    // The verdict expected for one packet.
    typedef struct packed {
        logic [7:0]  reply_type;
        logic        matched;
        logic [31:0] source;
        logic        truncated;
    } t_reply_verdict;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;

    ipr_in_if  in_bus ();
    ipr_out_if out_bus ();

    icmp_probe_reply_matcher dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_bus),
        .o_out       (out_bus),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #1 i_clk = ~i_clk;

    // Stimulus backlog, expected verdicts and run statistics.
    t_rx_byte       byte_backlog[$];
    t_reply_verdict verdict_q[$];
    t_rx_byte       cur_byte;
    bit             byte_loaded;
    int             wait_left;
    int             stall_left;
    bit             out_calm;
    int             error_count;
    int             bytes_taken;
    int             replies_checked;
    int             replies_matched;
    int             replies_short;
    int             id_settings;
    int             quiet_cycles;

    // Parser state of the prediction.
    logic [15:0] prober_id;
    int          pkt_pos;
    logic [7:0]  hdr_icmp_off;
    logic [7:0]  embed_ip_off;
    logic [7:0]  seen_type;
    logic [15:0] got_id;
    logic [15:0] got_seq;
    logic [31:0] got_source;
    logic [15:0] want_seq;
    bit          type_known;
    bit          want_embedded;
    bit          seq_complete;
    bit          in_frame;

    // Prints one line per mismatch and counts them all.
    task automatic flag_error(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        error_count++;
    endtask

    // Clears the parser state for a new packet.
    task automatic start_frame(input logic [15:0] seq);
        pkt_pos       = 0;
        hdr_icmp_off  = '0;
        embed_ip_off  = '0;
        seen_type     = '0;
        got_id        = '0;
        got_seq       = '0;
        got_source    = '0;
        want_seq      = seq;
        type_known    = 1'b0;
        want_embedded = 1'b0;
        seq_complete  = 1'b0;
        in_frame      = 1'b1;
    endtask

    // Applies one accepted byte to the parser and queues a verdict on the last byte.
    task automatic parse_rx_byte(input t_rx_byte b);
        int             p;
        int             d;
        t_reply_verdict v;
        if (b.first || !in_frame)
            start_frame(b.seq);
        p = pkt_pos;
        if (p < int'(MAX_PACKET_BYTES)) begin
            if (p == 0) begin
                hdr_icmp_off = {2'b00, b.data[3:0], 2'b00};
                embed_ip_off = hdr_icmp_off + EMBED_SKIP;
            end
            if (p >= 12 && p <= 15)
                got_source[8 * (3 - p[1:0]) +: 8] = b.data;
            if (!type_known) begin
                if (p == hdr_icmp_off) begin
                    seen_type     = b.data;
                    type_known    = 1'b1;
                    want_embedded = (b.data == TIME_EXCEEDED_TYPE);
                end
            end else if (want_embedded) begin
                // The embedded header's own length locates the inner ICMP header.
                if (p == embed_ip_off) begin
                    hdr_icmp_off  = embed_ip_off + {2'b00, b.data[3:0], 2'b00};
                    want_embedded = 1'b0;
                end
            end else if (p >= hdr_icmp_off) begin
                d = p - hdr_icmp_off;
                if (d == ICMP_ID_LO)
                    got_id[7:0] = b.data;
                else if (d == ICMP_ID_HI)
                    got_id[15:8] = b.data;
                else if (d == ICMP_SEQ_LO)
                    got_seq[7:0] = b.data;
                else if (d == ICMP_SEQ_HI) begin
                    got_seq[15:8] = b.data;
                    seq_complete  = 1'b1;
                end
            end
            pkt_pos = p + 1;
        end
        if (b.last) begin
            v.reply_type = type_known ? seen_type : 8'd0;
            v.matched    = seq_complete && got_id == prober_id && got_seq == want_seq;
            v.source     = got_source;
            v.truncated  = !seq_complete;
            verdict_q.push_back(v);
            in_frame = 1'b0;
        end
    endtask

    // Compares the reply on the output channel with the oldest expectation.
    task automatic check_reply();
        t_reply_verdict want;
        if (verdict_q.size() == 0) begin
            flag_error($sformatf("reply with no packet outstanding, type %0d",
                                 out_bus.reply_type));
        end else begin
            want = verdict_q.pop_front();
            if (out_bus.reply_type !== want.reply_type)
                flag_error($sformatf("reply_type got %0d want %0d",
                                     out_bus.reply_type, want.reply_type));
            if (out_bus.probe_matched !== want.matched)
                flag_error($sformatf("probe_matched got %0b want %0b",
                                     out_bus.probe_matched, want.matched));
            if (out_bus.source_address !== want.source)
                flag_error($sformatf("source_address got %h want %h",
                                     out_bus.source_address, want.source));
            if (out_bus.too_short !== want.truncated)
                flag_error($sformatf("too_short got %0b want %0b",
                                     out_bus.too_short, want.truncated));
            if (want.matched)
                replies_matched++;
            if (want.truncated)
                replies_short++;
        end
        replies_checked++;
    endtask

    // Driver: presents backlog bytes with random gaps and predicts each accepted byte.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
            byte_loaded = 1'b0;
            wait_left   = 0;
            prober_id   = '0;
            start_frame('0);
            in_frame = 1'b0;
        end else begin
            if (in_bus.valid && in_bus.ready) begin
                parse_rx_byte(cur_byte);
                bytes_taken++;
                byte_loaded = 1'b0;
                wait_left   = cur_byte.calm ? 0 : $urandom_range(0, 3);
            end
            if (!byte_loaded) begin
                if (wait_left != 0)
                    wait_left--;
                else if (byte_backlog.size() != 0 &&
                         !(byte_backlog[0].hold && verdict_q.size() != 0)) begin
                    cur_byte    = byte_backlog.pop_front();
                    byte_loaded = 1'b1;
                end
            end
            in_bus.valid             <= byte_loaded;
            in_bus.packet_byte       <= cur_byte.data;
            in_bus.first_byte        <= cur_byte.first;
            in_bus.last_byte         <= cur_byte.last;
            in_bus.expected_sequence <= cur_byte.seq;
        end
    end

    // Monitor: checks each reply and stalls the output channel at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
            stall_left = 0;
            out_calm   = 1'b0;
        end else begin
            if (out_bus.valid && out_bus.ready) begin
                check_reply();
                if (replies_checked % 16 == 0)
                    out_calm = ($urandom_range(0, 3) == 0);
                stall_left = out_calm ? 0 : $urandom_range(0, 3);
            end
            if (stall_left != 0) begin
                stall_left--;
                out_bus.ready <= 1'b0;
            end else begin
                out_bus.ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles without any transaction on either channel.
    always @(posedge i_clk) begin
        if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d replies outstanding",
                     quiet_cycles, verdict_q.size());
            $display("icmp_probe_reply_matcher regression: fail");
            $finish;
        end
    end

    // Appends one packet (or a fragment when closes is clear) to the backlog.
    task automatic queue_packet(input logic [7:0] pkt[$], input logic [15:0] seq,
                                input bit mark_first, input bit calm, input bit hold,
                                input bit closes);
        t_rx_byte item;
        foreach (pkt[i]) begin
            item.data  = pkt[i];
            item.first = (i == 0) && mark_first;
            item.last  = closes && (i == pkt.size() - 1);
            item.seq   = (i == 0) ? seq : 16'($urandom);
            item.calm  = calm;
            item.hold  = (i == 0) && hold;
            byte_backlog.push_back(item);
        end
    endtask

    // Builds a plausible reply; base returns where the matched ICMP header starts.
    task automatic build_reply(output logic [7:0] pkt[$], output int base,
                               input logic [15:0] seq, input bit time_exceeded);
        int          hdr_len;
        int          inner_len;
        int          icmp_at;
        int          embed_at;
        int          len;
        logic [7:0]  kind_byte;
        logic [15:0] id_val;
        logic [15:0] seq_val;
        hdr_len = ($urandom_range(0, 3) != 0) ? 5 : $urandom_range(0, 15);
        if (time_exceeded && hdr_len == 0)
            hdr_len = 1;
        inner_len = ($urandom_range(0, 3) != 0) ? 5 : $urandom_range(0, 15);
        icmp_at   = 4 * hdr_len;
        embed_at  = icmp_at + int'(EMBED_SKIP);
        base      = time_exceeded ? embed_at + 4 * inner_len : icmp_at;
        len = base + 8 + (($urandom_range(0, 5) == 0) ? $urandom_range(0, 40)
                                                       : $urandom_range(0, 4));
        pkt.delete();
        repeat (len) pkt.push_back(8'($urandom));

        // A zero header length makes byte 0 the type itself.
        if (hdr_len == 0) begin
            pkt[0] = {pkt[0][7:4], 4'h0};
        end else begin
            case ($urandom_range(0, 4))
                0, 1:    kind_byte = ICMP_ECHO_REPLY;
                2:       kind_byte = ICMP_DEST_UNREACHABLE;
                3:       kind_byte = ICMP_ECHO_REQUEST;
                default: kind_byte = 8'($urandom);
            endcase
            pkt[0]       = {4'h4, hdr_len[3:0]};
            pkt[icmp_at] = time_exceeded ? TIME_EXCEEDED_TYPE : kind_byte;
        end
        if (time_exceeded)
            pkt[embed_at] = {4'h4, inner_len[3:0]};

        // Mostly the outstanding probe, sometimes one bit off or unrelated.
        case ($urandom_range(0, 6))
            0:       id_val = prober_id ^ (16'h1 << $urandom_range(0, 15));
            1:       id_val = 16'($urandom);
            default: id_val = prober_id;
        endcase
        case ($urandom_range(0, 6))
            0:       seq_val = seq ^ (16'h1 << $urandom_range(0, 15));
            1:       seq_val = 16'($urandom);
            default: seq_val = seq;
        endcase
        pkt[base + ICMP_ID_LO]  = id_val[7:0];
        pkt[base + ICMP_ID_HI]  = id_val[15:8];
        pkt[base + ICMP_SEQ_LO] = seq_val[7:0];
        pkt[base + ICMP_SEQ_HI] = seq_val[15:8];
    endtask

    // Fills the backlog with one phase of mixed replies, fragments and noise.
    task automatic fill_phase(input int byte_goal);
        logic [7:0]  pkt[$];
        logic [15:0] seq;
        int          added;
        int          packets;
        int          kind;
        int          base;
        int          cut;
        bit          mark;
        added   = 0;
        packets = 0;
        while (added < byte_goal || packets < 4) begin
            seq  = 16'($urandom);
            mark = ($urandom_range(0, 6) != 0);
            // A fragment cut off by the first mark of the next packet.
            if ($urandom_range(0, 9) == 0) begin
                pkt.delete();
                repeat ($urandom_range(1, 10)) pkt.push_back(8'($urandom));
                queue_packet(pkt, 16'($urandom), 1'($urandom_range(0, 1)),
                             1'b0, 1'b0, 1'b0);
                added += pkt.size();
                mark = 1'b1;
            end
            kind = $urandom_range(0, 99);
            if (kind < 80) begin
                build_reply(pkt, base, seq, kind >= 40);
                if ($urandom_range(0, 7) == 0) begin
                    cut = $urandom_range(0, 1) ? $urandom_range(base + 4, base + 7)
                                               : $urandom_range(1, pkt.size() - 1);
                    while (pkt.size() > cut)
                        void'(pkt.pop_back());
                end
            end else begin
                pkt.delete();
                repeat ($urandom_range(1, 24)) pkt.push_back(8'($urandom));
            end
            queue_packet(pkt, seq, mark, $urandom_range(0, 4) == 0,
                         $urandom_range(0, 24) == 0, 1'b1);
            added += pkt.size();
            packets++;
        end
    endtask

    // Waits until every byte is taken and every reply has been checked.
    task automatic wait_idle();
        while (byte_backlog.size() != 0 || byte_loaded || verdict_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes the prober identifier while nothing is in flight.
    task automatic write_prober_id(input logic [15:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        prober_id = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        id_settings++;
    endtask

    // Sequencer: reset, directed packets, random phases and a closing packet.
    initial begin
        logic [7:0]  pkt[$];
        logic [15:0] seq;
        in_bus.valid             = 1'b0;
        in_bus.packet_byte       = '0;
        in_bus.first_byte        = 1'b0;
        in_bus.last_byte         = 1'b0;
        in_bus.expected_sequence = '0;
        out_bus.ready            = 1'b0;
        i_cfg_we                 = 1'b0;
        i_cfg_wdata              = '0;
        i_rst_n                  = 1'b0;
        error_count              = 0;
        bytes_taken              = 0;
        replies_checked          = 0;
        replies_matched          = 0;
        replies_short            = 0;
        id_settings              = 0;
        quiet_cycles             = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: a one-byte packet with both marks, all ones.
        pkt = {8'hFF};
        queue_packet(pkt, 16'hFFFF, 1'b1, 1'b0, 1'b0, 1'b1);
        // Zero header length puts the type at byte 0; matches the reset identifier.
        pkt = {8'h00, 8'hA5, 8'h5A, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF};
        queue_packet(pkt, 16'hFFFF, 1'b1, 1'b0, 1'b0, 1'b1);
        // No first mark after a last byte; identifier all ones does not match.
        pkt = {8'hF0, 8'h12, 8'h34, 8'h56, 8'hFF, 8'hFF, 8'h00, 8'h00};
        queue_packet(pkt, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b1);
        // A packet restarted by a first mark part way through.
        pkt = {8'h45, 8'h00, 8'h00};
        queue_packet(pkt, 16'hBEEF, 1'b1, 1'b0, 1'b0, 1'b0);
        pkt = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h34, 8'h12};
        queue_packet(pkt, 16'h1234, 1'b1, 1'b0, 1'b1, 1'b1);
        wait_idle();

        // Random phases, each under a different identifier.
        write_prober_id(16'hFFFF);
        fill_phase(PHASE_BYTES);
        wait_idle();
        write_prober_id(16'($urandom));
        fill_phase(PHASE_BYTES);
        wait_idle();
        write_prober_id(16'h0000);
        fill_phase(PHASE_BYTES);
        wait_idle();
        write_prober_id(16'($urandom));
        fill_phase(PHASE_BYTES);
        wait_idle();

        // A packet without a first mark after a finished one starts from position zero.
        write_prober_id(16'($urandom));
        seq = 16'($urandom);
        pkt = {8'h00, 8'h11, 8'h22, 8'h33, prober_id[7:0], prober_id[15:8],
               seq[7:0], seq[15:8]};
        queue_packet(pkt, seq, 1'b0, 1'b0, 1'b0, 1'b1);
        wait_idle();

        $display("Covered %0d packet bytes and %0d replies (%0d matched, %0d too short)",
                 bytes_taken, replies_checked, replies_matched, replies_short);
        $display("under %0d identifier settings; %0d mismatches found.",
                 id_settings + 1, error_count);
        if (error_count == 0)
            $display("icmp_probe_reply_matcher regression: pass");
        else
            $display("icmp_probe_reply_matcher regression: fail");
        $finish;
    end

endmodule
